[rtl/rtcm_pkg.sv]
// shared types and constants for the three-wire rtc serial master
package rtcm_pkg;

  // longest burst of data bytes after the command byte
  localparam int MaxBurst = 31;

  // configuration register indexes
  localparam logic RegHalfPeriod = 1'b0;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_WBYTE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // transaction phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_WAIT = 3'd2,
    PH_WBIT = 3'd3,
    PH_RBIT = 3'd4
  } phase_t;

  // controller state carried from item to item
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [4:0]  bytes_left;
    logic        reading;
    logic [7:0]  tick_count;
    logic        pin_ce;
    logic        pin_clk;
    logic        pin_dat;
    logic        pin_drv;
  } rtc_state_t;

  // one input item
  typedef struct packed {
    req_t        req_type;
    logic [7:0]  command;
    logic [4:0]  byte_count;
    logic [7:0]  write_data;
    logic        io_in;
  } step_in_t;

  // one result item
  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        data_out;
    logic        data_drive;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        need_write_byte;
    logic        busy_res;
  } step_out_t;

endpackage

[rtl/rtcm_step.sv]
// per-item update of the serial master: state plus one item gives next state and result
module rtcm_step (
  input  rtcm_pkg::rtc_state_t state_cur,
  input  rtcm_pkg::step_in_t   item,
  input  logic [7:0]           half_period,
  output rtcm_pkg::rtc_state_t state_nxt,
  output rtcm_pkg::step_out_t  result
);

  logic [7:0] hp_eff;
  logic [7:0] tick_inc;
  logic [2:0] bit_inc;
  logic [4:0] bytes_dec;
  logic       rd_valid;
  logic [7:0] rd_byte;

  assign hp_eff    = (half_period == 8'd0) ? 8'd1 : half_period;
  assign tick_inc  = state_cur.tick_count + 8'd1;
  assign bit_inc   = state_cur.bit_index + 3'd1;
  assign bytes_dec = (state_cur.bytes_left != 5'd0) ? (state_cur.bytes_left - 5'd1)
                                                    : 5'd0;

  // request handling and half bit steps
  always_comb begin
    state_nxt = state_cur;
    rd_valid  = 1'b0;
    rd_byte   = 8'd0;
    if (item.req_type == rtcm_pkg::REQ_START && state_cur.phase == rtcm_pkg::PH_IDLE) begin
      state_nxt.phase      = rtcm_pkg::PH_CMD;
      state_nxt.reading    = item.command[0];
      state_nxt.bytes_left = (32'(item.byte_count) > rtcm_pkg::MaxBurst)
                             ? 5'(rtcm_pkg::MaxBurst) : item.byte_count;
      state_nxt.shift_byte = item.command;
      state_nxt.bit_index  = 3'd0;
      state_nxt.tick_count = 8'd0;
      state_nxt.pin_ce     = 1'b1;
      state_nxt.pin_clk    = 1'b0;
      state_nxt.pin_dat    = item.command[0];
      state_nxt.pin_drv    = 1'b1;
    end else if (item.req_type == rtcm_pkg::REQ_WBYTE &&
                 state_cur.phase == rtcm_pkg::PH_WAIT) begin
      state_nxt.phase      = rtcm_pkg::PH_WBIT;
      state_nxt.shift_byte = item.write_data;
      state_nxt.bit_index  = 3'd0;
      state_nxt.tick_count = 8'd0;
    end else if (item.req_type == rtcm_pkg::REQ_TICK &&
                 (state_cur.phase == rtcm_pkg::PH_CMD ||
                  state_cur.phase == rtcm_pkg::PH_WBIT ||
                  state_cur.phase == rtcm_pkg::PH_RBIT)) begin
      state_nxt.tick_count = tick_inc;
      if (tick_inc >= hp_eff) begin
        state_nxt.tick_count = 8'd0;
        if (state_cur.phase == rtcm_pkg::PH_RBIT) begin
          // read bit: rising step, then falling step samples the pin
          if (!state_cur.pin_clk) begin
            state_nxt.pin_clk = 1'b1;
          end else begin
            state_nxt.pin_clk    = 1'b0;
            state_nxt.shift_byte = {item.io_in, state_cur.shift_byte[7:1]};
            state_nxt.bit_index  = bit_inc;
            if (bit_inc == 3'd0) begin
              state_nxt.bytes_left = bytes_dec;
              rd_valid = 1'b1;
              rd_byte  = state_nxt.shift_byte;
              if (bytes_dec == 5'd0) begin
                state_nxt.phase   = rtcm_pkg::PH_IDLE;
                state_nxt.pin_ce  = 1'b0;
                state_nxt.pin_dat = 1'b0;
                state_nxt.pin_drv = 1'b0;
              end
            end
          end
        end else if (state_cur.pin_clk) begin
          // send bit: falling step drives the next bit
          state_nxt.pin_clk = 1'b0;
          state_nxt.pin_dat = state_cur.shift_byte[0];
          state_nxt.pin_drv = 1'b1;
        end else begin
          // send bit: rising step latches it in the device
          state_nxt.pin_clk    = 1'b1;
          state_nxt.shift_byte = {1'b0, state_cur.shift_byte[7:1]};
          state_nxt.bit_index  = bit_inc;
          if (bit_inc == 3'd0) begin
            if (state_cur.phase == rtcm_pkg::PH_WBIT) begin
              state_nxt.bytes_left = bytes_dec;
            end
            if (state_nxt.bytes_left == 5'd0) begin
              state_nxt.phase   = rtcm_pkg::PH_IDLE;
              state_nxt.pin_ce  = 1'b0;
              state_nxt.pin_dat = 1'b0;
              state_nxt.pin_drv = 1'b0;
            end else if (state_cur.reading) begin
              state_nxt.phase      = rtcm_pkg::PH_RBIT;
              state_nxt.shift_byte = 8'd0;
              state_nxt.pin_dat    = 1'b0;
              state_nxt.pin_drv    = 1'b0;
            end else begin
              state_nxt.phase = rtcm_pkg::PH_WAIT;
            end
          end
        end
      end
    end
  end

  // pin levels and status after the update
  always_comb begin
    result.chip_enable     = state_nxt.pin_ce;
    result.serial_clock    = state_nxt.pin_clk;
    result.data_out        = state_nxt.pin_drv & state_nxt.pin_dat;
    result.data_drive      = state_nxt.pin_drv;
    result.read_byte       = rd_byte;
    result.read_valid      = rd_valid;
    result.need_write_byte = (state_nxt.phase == rtcm_pkg::PH_WAIT);
    result.busy_res        = (state_nxt.phase != rtcm_pkg::PH_IDLE);
  end

endmodule

[rtl/three_wire_rtc_serial_master_core.sv]
// top level of the three-wire rtc serial master: stream ports, config register, pipeline
// Each input transaction is a time tick, a start request, a write byte or none; every one
// gives exactly one result transaction with the pin levels and status after it.
// The block takes one transaction per cycle while the result stream does not stall; an
// accepted input passes through the input register, the combinational state update and
// the result register, which holds the result until it is taken.
// half_period (address 0) counts ticks per half bit of the serial clock, 0 acting
// as 1; the user must write it only while idle, which the block does not enforce.
module three_wire_rtc_serial_master_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[7:0], byte_count[12:8], write_data[20:13], io_in[21]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // chip_enable[0], serial_clock[1], data_out[2],
                                  // data_drive[3], read_byte[11:4], need_write_byte[12],
                                  // busy_res[13]
  output logic        out_tuser,  // read_valid[0]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                 in_full_r;
  rtcm_pkg::step_in_t   in_item_r;
  rtcm_pkg::rtc_state_t state_r;
  rtcm_pkg::rtc_state_t state_nxt;
  rtcm_pkg::step_out_t  step_res;
  logic                 out_valid_r;
  rtcm_pkg::step_out_t  out_res_r;
  logic [7:0]           half_period_r;
  logic                 advance;
  logic                 in_fire;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rtcm_pkg::RegHalfPeriod) ? {24'd0, half_period_r}
                                                                : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == rtcm_pkg::RegHalfPeriod) begin
      half_period_r <= cfg_pwdata[7:0];
    end
  end

  // handshake: the stage moves when the result register is free or draining
  assign advance   = in_full_r && (!out_valid_r || out_tready);
  assign in_tready = !in_full_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_fire) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.req_type   <= rtcm_pkg::req_t'(in_tuser);
      in_item_r.command    <= in_tdata[7:0];
      in_item_r.byte_count <= in_tdata[12:8];
      in_item_r.write_data <= in_tdata[20:13];
      in_item_r.io_in      <= in_tdata[21];
    end
  end

  // per-item update
  rtcm_step u_step (
    .state_cur   (state_r),
    .item        (in_item_r),
    .half_period (half_period_r),
    .state_nxt   (state_nxt),
    .result      (step_res)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: rtcm_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.read_valid;
  assign out_tdata  = {2'b00, out_res_r.busy_res, out_res_r.need_write_byte,
                       out_res_r.read_byte, out_res_r.data_drive, out_res_r.data_out,
                       out_res_r.serial_clock, out_res_r.chip_enable};

endmodule
